[rtl/core/vac_pkg.sv]
// ----------------------------------------------------------------------------
// vac_pkg: shared types and constants of the vertex attribute compressor
// Beat payloads, quantizer widths and the lane layout of the divider pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package vac_pkg;

   localparam int QUANT_BITS = 16;
   localparam int QMAX       = (1 << QUANT_BITS) - 1;
   localparam int NUM_W      = 50;   // dividend width, 2*d*QMAX + r < 2^50
   localparam int DEN_W      = 34;   // divisor width, 2*range < 2^34
   localparam int LANES      = 5;    // three position axes, two normal codes
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_Z = 3'd5;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
   } req_type;

   typedef struct packed {
      logic [15:0] qpos_x;
      logic [15:0] qpos_y;
      logic [15:0] qpos_z;
      logic [15:0] oct_u;
      logic [15:0] oct_v;
      logic [15:0] qtex_u;
      logic [15:0] qtex_v;
   } rsp_type;

   typedef struct packed {
      logic [15:0] u;
      logic [15:0] v;
   } tex_type;

   typedef logic [LANES-1:0][NUM_W-1:0]      num_vec_type;
   typedef logic [LANES-1:0][DEN_W-1:0]      den_vec_type;
   typedef logic [LANES-1:0][QUANT_BITS-1:0] quo_vec_type;

endpackage

`default_nettype wire

[rtl/core/vertex_attribute_compressor.sv]
// A request beat is registered in stage A, stage B and each divider stage before it appears as a response.
// Throughput: one vertex per cycle; the divider pipe retires one quotient bit
// per stage for all five lanes, and the whole pipe holds while rsp is stalled.
// Reset clears the bounds registers to 0 and empties the pipeline.
// ----------------------------------------------------------------------------
// vertex_attribute_compressor: position, normal and texcoord quantizer
// Box-relative position codes, octahedral normal codes, 16-bit texcoords.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_attribute_compressor (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire vac_pkg::req_type                    req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output vac_pkg::rsp_type                         rsp_payload,
   input  wire logic                                csr_we,
   input  wire logic [vac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [31:0]                         csr_wdata
);
   import vac_pkg::*;

   logic signed [31:0] min_ff [3];
   logic signed [31:0] max_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MIN_X: min_ff[0] <= csr_wdata;
            REG_MIN_Y: min_ff[1] <= csr_wdata;
            REG_MIN_Z: min_ff[2] <= csr_wdata;
            REG_MAX_X: max_ff[0] <= csr_wdata;
            REG_MAX_Y: max_ff[1] <= csr_wdata;
            REG_MAX_Z: max_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // stage A: differences, normal magnitudes, texcoord codes
   logic               a_valid_ff;
   logic signed [33:0] a_d_ff [3];
   logic signed [33:0] a_r_ff [3];
   logic               a_negx_ff, a_negy_ff, a_negz_ff;
   logic signed [16:0] a_nx_ff, a_ny_ff;
   logic [16:0]        a_ax_ff, a_ay_ff, a_sum_ff;
   tex_type            a_tex_ff;

   logic signed [31:0] pos_in [3];
   logic signed [33:0] a_d_in [3];
   logic signed [33:0] a_r_in [3];
   logic [16:0]        ax_in, ay_in, az_in, sum_in;
   tex_type            tex_in;

   function automatic logic [15:0] quant_tex(input logic signed [31:0] t);
      logic [47:0] prod;
      prod = ({16'd0, t} << 16) - {16'd0, t} + 48'd32768;
      if (t <= 0) begin
         return 16'd0;
      end else if (prod[47:32] != 16'd0) begin
         return 16'hFFFF;
      end
      return prod[31:16];
   endfunction

   function automatic logic [16:0] abs17(input logic signed [15:0] v);
      logic signed [16:0] w;
      w = 17'(v);
      return v[15] ? 17'(-w) : 17'(w);
   endfunction

   always_comb begin
      pos_in[0] = req_payload.pos_x;
      pos_in[1] = req_payload.pos_y;
      pos_in[2] = req_payload.pos_z;
      for (int i = 0; i < 3; i++) begin
         a_d_in[i] = 34'(pos_in[i]) - 34'(min_ff[i]);
         a_r_in[i] = 34'(max_ff[i]) - 34'(min_ff[i]);
      end
      ax_in    = abs17(req_payload.normal_x);
      ay_in    = abs17(req_payload.normal_y);
      az_in    = abs17(req_payload.normal_z);
      sum_in   = ax_in + ay_in + az_in;
      tex_in.u = quant_tex(req_payload.tex_u);
      tex_in.v = quant_tex(req_payload.tex_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_d_ff    <= a_d_in;
         a_r_ff    <= a_r_in;
         a_negx_ff <= req_payload.normal_x[15];
         a_negy_ff <= req_payload.normal_y[15];
         a_negz_ff <= req_payload.normal_z[15];
         a_nx_ff   <= 17'(req_payload.normal_x);
         a_ny_ff   <= 17'(req_payload.normal_y);
         a_ax_ff   <= ax_in;
         a_ay_ff   <= ay_in;
         a_sum_ff  <= sum_in;
         a_tex_ff  <= tex_in;
      end
   end

   // stage B: special cases, fold, dividend and divisor per lane
   logic        b_valid_ff;
   num_vec_type b_num_ff;
   den_vec_type b_den_ff;
   tex_type     b_tex_ff;
   num_vec_type num_in;
   den_vec_type den_in;

   function automatic logic [NUM_W-1:0] oct_num(input logic signed [18:0] n,
                                               input logic [16:0] s);
      logic [NUM_W-1:0] nw;
      nw = NUM_W'(unsigned'(n[17:0]));
      return (nw << QUANT_BITS) - nw + NUM_W'(s);
   endfunction

   always_comb begin
      logic [32:0]        dd;
      logic signed [18:0] sum19, fa, fb, na, nb;
      for (int i = 0; i < 3; i++) begin
         dd = a_d_ff[i][32:0];
         if (a_r_ff[i] <= 0 || a_d_ff[i] <= 0) begin
            num_in[i] = '0;
            den_in[i] = DEN_W'(1);
         end else if (a_d_ff[i] >= a_r_ff[i]) begin
            num_in[i] = NUM_W'(QMAX);
            den_in[i] = DEN_W'(1);
         end else begin
            num_in[i] = (NUM_W'(dd) << (QUANT_BITS + 1)) - (NUM_W'(dd) << 1)
                        + NUM_W'(a_r_ff[i][32:0]);
            den_in[i] = {a_r_ff[i][32:0], 1'b0};
         end
      end
      sum19 = 19'(a_sum_ff);
      fa    = sum19 - 19'(a_ay_ff);
      fb    = sum19 - 19'(a_ax_ff);
      if (a_negz_ff) begin
         // fold the lower hemisphere onto the outer triangles
         na = a_negx_ff ? (sum19 - fa) : (sum19 + fa);
         nb = a_negy_ff ? (sum19 - fb) : (sum19 + fb);
      end else begin
         na = sum19 + 19'(a_nx_ff);
         nb = sum19 + 19'(a_ny_ff);
      end
      if (a_sum_ff == '0) begin
         num_in[3] = NUM_W'(1) << (QUANT_BITS - 1);
         num_in[4] = NUM_W'(1) << (QUANT_BITS - 1);
         den_in[3] = DEN_W'(1);
         den_in[4] = DEN_W'(1);
      end else begin
         num_in[3] = oct_num(na, a_sum_ff);
         num_in[4] = oct_num(nb, a_sum_ff);
         den_in[3] = DEN_W'({a_sum_ff, 1'b0});
         den_in[4] = DEN_W'({a_sum_ff, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_num_ff <= num_in;
         b_den_ff <= den_in;
         b_tex_ff <= a_tex_ff;
      end
   end

   quo_vec_type quo;
   tex_type     out_tex;

   vac_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_num    (b_num_ff),
      .in_den    (b_den_ff),
      .in_tex    (b_tex_ff),
      .out_valid (rsp_valid),
      .out_quo   (quo),
      .out_tex   (out_tex)
   );

   always_comb begin
      rsp_payload.qpos_x = 16'(quo[0]);
      rsp_payload.qpos_y = 16'(quo[1]);
      rsp_payload.qpos_z = 16'(quo[2]);
      rsp_payload.oct_u  = 16'(quo[3]);
      rsp_payload.oct_v  = 16'(quo[4]);
      rsp_payload.qtex_u = out_tex.u;
      rsp_payload.qtex_v = out_tex.v;
   end

   a_reset_empty: assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");
   a_stage_a_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !en) |=> a_valid_ff)
      else $error("stage A beat lost during stall");
   a_stage_b_hold: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !en) |=> (b_valid_ff && $stable(b_num_ff)))
      else $error("stage B beat changed during stall");

endmodule

`default_nettype wire

[rtl/core/vac_div.sv]
// ----------------------------------------------------------------------------
// vac_div: pipelined restoring divider, five lanes
// One quotient bit per stage, QUANT_BITS stages; texture codes ride along.
// ----------------------------------------------------------------------------
`default_nettype none

module vac_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire vac_pkg::num_vec_type in_num,
   input  wire vac_pkg::den_vec_type in_den,
   input  wire vac_pkg::tex_type     in_tex,
   output logic                      out_valid,
   output vac_pkg::quo_vec_type      out_quo,
   output vac_pkg::tex_type          out_tex
);
   import vac_pkg::*;

   logic                  valid_ff [QUANT_BITS];
   tex_type               tex_ff   [QUANT_BITS];
   num_vec_type           rem_ff   [QUANT_BITS];
   den_vec_type           den_ff   [QUANT_BITS];
   quo_vec_type           quo_ff   [QUANT_BITS];

   for (genvar k = 0; k < QUANT_BITS; k++) begin : g_stage
      localparam int SH = QUANT_BITS - 1 - k;
      logic        src_valid;
      tex_type     src_tex;
      num_vec_type src_rem;
      den_vec_type src_den;
      quo_vec_type src_quo;
      num_vec_type rem_in;
      quo_vec_type quo_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_tex   = in_tex;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quo   = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_tex   = tex_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quo   = quo_ff[k-1];
      end

      always_comb begin
         logic [NUM_W-1:0] dsh;
         logic             take;
         for (int l = 0; l < LANES; l++) begin
            dsh       = NUM_W'(src_den[l]) << SH;
            take      = (src_rem[l] >= dsh);
            rem_in[l] = take ? (src_rem[l] - dsh) : src_rem[l];
            quo_in[l] = {src_quo[l][QUANT_BITS-2:0], take};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tex_ff[k] <= src_tex;
            rem_ff[k] <= rem_in;
            den_ff[k] <= src_den;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[QUANT_BITS-1];
   assign out_quo   = quo_ff[QUANT_BITS-1];
   assign out_tex   = tex_ff[QUANT_BITS-1];

endmodule

`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: vertex attribute compressor testbench
// Drives vertex beats through several bounds settings and idle phases, and
// checks every response against a local integer model of the quantizers.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vac_pkg::*;

   localparam longint CODE_MAX   = (64'd1 << QUANT_BITS) - 1;
   localparam int     CYCLE_CAP  = 1500000;
   localparam int     PIPE_DRAIN = QUANT_BITS + 8;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]   csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   vertex_attribute_compressor i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatch_count++;
   endtask

   class vertex_scoreboard;
      logic signed [31:0] box_lo[3];
      logic signed [31:0] box_hi[3];
      rsp_type pending_codes[$];

      function new();
         foreach (box_lo[i]) begin
            box_lo[i] = '0;
            box_hi[i] = '0;
         end
      endfunction

      function void write_bound(int idx, logic [31:0] value);
         if (idx < 3) box_lo[idx] = value;
         else if (idx < 6) box_hi[idx-3] = value;
      endfunction

      function longint axis_code(longint p, longint lo, longint hi);
         longint span, d;
         span = hi - lo;
         d = p - lo;
         if (span <= 0 || d <= 0) return 0;
         if (d >= span) return CODE_MAX;
         return (2 * d * CODE_MAX + span) / (2 * span);
      endfunction

      function longint oct_code(longint a, longint sum);
         return ((a + sum) * CODE_MAX + sum) / (2 * sum);
      endfunction

      function longint tex_code(longint t);
         longint q;
         if (t <= 0) return 0;
         q = (t * 65535 + 32768) >>> 16;
         return (q > 65535) ? 65535 : q;
      endfunction

      function void note_vertex(req_type v);
         rsp_type r;
         longint nx, ny, nz, ax, ay, az, sum, a, b;
         r.qpos_x = 16'(axis_code(v.pos_x, box_lo[0], box_hi[0]));
         r.qpos_y = 16'(axis_code(v.pos_y, box_lo[1], box_hi[1]));
         r.qpos_z = 16'(axis_code(v.pos_z, box_lo[2], box_hi[2]));
         nx = v.normal_x;
         ny = v.normal_y;
         nz = v.normal_z;
         ax = nx < 0 ? -nx : nx;
         ay = ny < 0 ? -ny : ny;
         az = nz < 0 ? -nz : nz;
         sum = ax + ay + az;
         if (sum == 0) begin
            r.oct_u = 16'(64'd1 << (QUANT_BITS - 1));
            r.oct_v = r.oct_u;
         end else begin
            a = nx;
            b = ny;
            if (nz < 0) begin
               // fold lower hemisphere over the diagonals
               a = (nx >= 0) ? (sum - ay) : -(sum - ay);
               b = (ny >= 0) ? (sum - ax) : -(sum - ax);
            end
            r.oct_u = 16'(oct_code(a, sum));
            r.oct_v = 16'(oct_code(b, sum));
         end
         r.qtex_u = 16'(tex_code(v.tex_u));
         r.qtex_v = 16'(tex_code(v.tex_v));
         pending_codes.push_back(r);
      endfunction

      task check_codes(rsp_type got);
         rsp_type want;
         if (pending_codes.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
            return;
         end
         want = pending_codes.pop_front();
         if (got.qpos_x !== want.qpos_x) report_mismatch("qpos_x", got.qpos_x, want.qpos_x);
         if (got.qpos_y !== want.qpos_y) report_mismatch("qpos_y", got.qpos_y, want.qpos_y);
         if (got.qpos_z !== want.qpos_z) report_mismatch("qpos_z", got.qpos_z, want.qpos_z);
         if (got.oct_u !== want.oct_u) report_mismatch("oct_u", got.oct_u, want.oct_u);
         if (got.oct_v !== want.oct_v) report_mismatch("oct_v", got.oct_v, want.oct_v);
         if (got.qtex_u !== want.qtex_u) report_mismatch("qtex_u", got.qtex_u, want.qtex_u);
         if (got.qtex_v !== want.qtex_v) report_mismatch("qtex_v", got.qtex_v, want.qtex_v);
      endtask
   endclass

   vertex_scoreboard codes_sb = new();

   // receiver: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) codes_sb.check_codes(rsp_payload);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // leaves the write enable high; the caller drops it after the last write
   task automatic write_bound(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      codes_sb.write_bound(idx, value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (codes_sb.pending_codes.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic send_vertex(input req_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      codes_sb.note_vertex(v);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return 32'h7fff_ffff - $urandom_range(3);
         default: return $signed($urandom_range(262143)) - 131072;
      endcase
   endfunction

   function automatic logic [15:0] pick_normal();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return '0;
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_vertex();
      req_type v;
      v.pos_x = pick_word();
      v.pos_y = pick_word();
      v.pos_z = pick_word();
      v.normal_x = pick_normal();
      v.normal_y = pick_normal();
      v.normal_z = pick_normal();
      v.tex_u = ($urandom_range(1)) ? pick_word() : $urandom_range(32'h1_1000);
      v.tex_v = ($urandom_range(1)) ? pick_word() : $urandom_range(32'h1_1000);
      return v;
   endfunction

   task automatic random_bounds(input int style);
      logic signed [31:0] lo, hi;
      for (int a = 0; a < 3; a++) begin
         case (style)
            0: begin lo = 32'sh8000_0000; hi = 32'sh7fff_ffff; end
            1: begin lo = 32'sh7fff_ffff; hi = 32'sh8000_0000; end
            2: begin lo = $urandom(); hi = lo; end
            default: begin
               lo = $signed($urandom_range(262143)) - 131072;
               hi = lo + $urandom_range(200000);
            end
         endcase
         write_bound(CSR_IDX_W'(REG_MIN_X + a), lo);
         write_bound(CSR_IDX_W'(REG_MAX_X + a), hi);
      end
      // out of range index: ignored
      write_bound(3'd7, $urandom());
      csr_we <= 1'b0;
   endtask

   initial begin
      req_type v;
      int phase_pct[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{25, 25}};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: small random bounds, then edge vertices
      random_bounds(3);
      for (int i = 0; i < 20; i++) begin
         v = '0;
         case (i)
            0: ;
            1: begin v.normal_x = 16'h7fff; v.tex_u = 32'h1_0000; v.tex_v = -1; end
            2: begin v.normal_x = 16'h8000; v.normal_z = 16'h8000; end
            3: begin v.normal_y = 16'h8000; v.normal_z = -16'sd1; end
            4: begin v.normal_z = 16'h8000; v.tex_u = 32'h7fff_ffff; v.tex_v = 32'h8000_0000; end
            5: begin v.normal_x = 16'h8000; v.normal_y = 16'h8000; v.normal_z = 16'h8000; end
            6: begin v.normal_x = 100; v.normal_y = -200; v.normal_z = -300; end
            7: begin v.tex_u = 32'h0000_8000; v.tex_v = 1; end
            8: begin
               v.pos_x = 32'h8000_0000; v.pos_y = 32'h7fff_ffff; v.pos_z = codes_sb.box_lo[2];
            end
            9: begin v.pos_x = codes_sb.box_hi[0]; v.pos_y = codes_sb.box_lo[1] + 1; end
            default: v = random_vertex();
         endcase
         send_vertex(v);
      end
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         send_idle_pct = phase_pct[p % 4][0];
         recv_stall_pct = phase_pct[p % 4][1];
         random_bounds(p < 4 ? p : 3);
         if (p == 5) hold_off_cycles = 300;
         for (int i = 0; i < 220; i++) send_vertex(random_vertex());
         wait_drained();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

`default_nettype wire
